FILE: src/prdl_pkg.sv
// shared types and constants for the probe request dedup log
// used by the front parser, queue, back lookup engine, top level and checker
package prdl_pkg;

  localparam int RingDepthDef    = 24;
  localparam int MaxSsidBytesDef = 32;
  localparam int MaxFrameBytesDef = 4096;

  localparam int ADDR_W   = 48;
  localparam int SSID_W   = 256;
  localparam int LEN_W    = 6;
  localparam int RSSI_W   = 8;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 5;
  localparam int KEY_W    = ADDR_W + SSID_W + LEN_W;
  localparam int ENTRY_W  = KEY_W + RSSI_W;

  localparam logic [3:0] SUBTYPE_PROBE = 4'h4;
  localparam logic [7:0] SSID_ELEM_ID  = 8'h00;
  localparam int         HDR_BYTES     = 24;
  localparam int         SA_FIRST      = 10;
  localparam int         SA_LAST       = 15;

  typedef enum logic [2:0] {
    ST_NOT_PROBE = 3'd0,
    ST_NO_SSID   = 3'd1,
    ST_DUP       = 3'd2,
    ST_STORED    = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_REPORT,
    JOB_LOOKUP
  } job_kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    job_kind_e           kind;
    status_e             status;
    logic [ADDR_W-1:0]   addr;
    logic [SSID_W-1:0]   ssid;
    logic [LEN_W-1:0]    len;
    logic [RSSI_W-1:0]   rssi;
  } job_t;

endpackage

FILE: src/prdl_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module prdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/prdl_front.sv
// front parser: takes frame bytes, extracts source address and ssid, emits jobs
// depends on prdl_pkg
module prdl_front import prdl_pkg::*; #(
  parameter int MAX_SSID_BYTES  = MaxSsidBytesDef,
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_clear_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       mgmt_i,
  input  logic [7:0] rssi_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int NW = PW + 2;

  logic [PW-1:0]     pos_q, pos_d;
  logic [NW-1:0]     nes_q, nes_d;
  logic [7:0]        id_q, id_d, len_q, len_d;
  logic [ADDR_W-1:0] sa_q, sa_d;
  logic [SSID_W-1:0] ssid_q, ssid_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic              sub_q, sub_d, capg_q, capg_d, capd_q, capd_d;
  logic              ovf_q, ovf_d, hid_q, hid_d, zero_q, zero_d;
  logic [5:0]        off;

  assign off = 6'(NW'(pos_q) - nes_q);

  always_comb begin
    pos_d = pos_q; nes_d = nes_q; id_d = id_q; len_d = len_q; sa_d = sa_q;
    ssid_d = ssid_q; n_d = n_q; sub_d = sub_q; capg_d = capg_q; capd_d = capd_q;
    ovf_d = ovf_q; hid_d = hid_q; zero_d = zero_q;
    push_o = 1'b0;
    job_o = '0;
    job_o.kind = JOB_REPORT;
    job_o.status = ST_NOT_PROBE;
    if (accept_i && req_clear_i) begin
      push_o = 1'b1;
      job_o.kind = JOB_CLEAR;
      job_o.status = ST_CLEARED;
    end else if (accept_i) begin
      if (pos_q >= PW'(MAX_FRAME_BYTES)) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + PW'(1);
        if (pos_q == '0) begin
          sub_d = (byte_i[7:4] == SUBTYPE_PROBE);
        end
        if (pos_q >= PW'(SA_FIRST) && pos_q <= PW'(SA_LAST)) begin
          sa_d = {sa_q[ADDR_W-9:0], byte_i};
        end
        if (capd_q) begin
          // ssid already taken, ignore the rest
        end else if (capg_q) begin
          if (off < 6'(MAX_SSID_BYTES) && !zero_q) begin
            if (byte_i == 8'h00) begin
              zero_d = 1'b1;
            end else begin
              ssid_d[off[4:0]*8 +: 8] = byte_i;
              n_d = off + 6'd1;
            end
          end
          if (8'(off) + 8'd1 >= len_q) begin
            capg_d = 1'b0;
            capd_d = 1'b1;
          end
        end else if (hid_q) begin
          len_d = byte_i;
          hid_d = 1'b0;
          if (id_q == SSID_ELEM_ID && byte_i >= 8'd1 && byte_i <= 8'd32) begin
            capg_d = 1'b1;
            nes_d = NW'(pos_q) + NW'(1);
          end else begin
            nes_d = nes_q + NW'(2) + NW'(byte_i);
          end
        end else if (pos_q >= PW'(HDR_BYTES) && NW'(pos_q) == nes_q) begin
          id_d = byte_i;
          hid_d = 1'b1;
        end
      end
      if (last_i) begin
        push_o = 1'b1;
        job_o.addr = sa_d;
        job_o.ssid = ssid_d;
        job_o.len = n_d;
        job_o.rssi = rssi_i;
        if (ovf_d) begin
          job_o.status = ST_TOO_LONG;
        end else if (!mgmt_i || pos_d < PW'(HDR_BYTES) || !sub_d) begin
          job_o.status = ST_NOT_PROBE;
        end else if (!capd_d || n_d == '0) begin
          job_o.status = ST_NO_SSID;
        end else begin
          job_o.kind = JOB_LOOKUP;
          job_o.status = ST_STORED;
        end
        // restart for the next frame
        pos_d = '0; nes_d = NW'(HDR_BYTES); id_d = '0; len_d = '0; sa_d = '0;
        ssid_d = '0; n_d = '0; sub_d = 1'b0; capg_d = 1'b0; capd_d = 1'b0;
        ovf_d = 1'b0; hid_d = 1'b0; zero_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; nes_q <= NW'(HDR_BYTES); id_q <= '0; len_q <= '0; sa_q <= '0;
      ssid_q <= '0; n_q <= '0; sub_q <= 1'b0; capg_q <= 1'b0; capd_q <= 1'b0;
      ovf_q <= 1'b0; hid_q <= 1'b0; zero_q <= 1'b0;
    end else begin
      pos_q <= pos_d; nes_q <= nes_d; id_q <= id_d; len_q <= len_d; sa_q <= sa_d;
      ssid_q <= ssid_d; n_q <= n_d; sub_q <= sub_d; capg_q <= capg_d; capd_q <= capd_d;
      ovf_q <= ovf_d; hid_q <= hid_d; zero_q <= zero_d;
    end
  end

endmodule

FILE: src/prdl_fifo.sv
// two-entry job queue between the parser and the lookup engine
// depends on prdl_pkg
module prdl_fifo import prdl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: src/prdl_back.sv
// back engine: ring lookup, insert, clear and the output register
// depends on prdl_pkg and prdl_ram
module prdl_back import prdl_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [15:0] m_data_o
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  back_state_e     state_q, state_d;
  job_t            job_q, job_d;
  logic [IW-1:0]   idx_q, idx_d, ws_q, ws_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [RING_DEPTH-1:0] valid_q, valid_d;
  status_e         res_st_q, res_st_d;
  logic [IW-1:0]   res_slot_q, res_slot_d;
  logic            out_vld_q, out_vld_d;
  logic [15:0]     out_q, out_d;
  logic            ram_we, ram_re, match;
  logic [ENTRY_W-1:0] ram_rdata;

  prdl_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ws_q),
    .wdata_i ({job_q.addr, job_q.ssid, job_q.len, job_q.rssi}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign match = valid_q[idx_q] &&
                 (ram_rdata[ENTRY_W-1:RSSI_W] == {job_q.addr, job_q.ssid, job_q.len});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) state_d = (job_i.kind == JOB_LOOKUP) ? B_READ : B_EMIT;
      end
      B_READ: state_d = B_CMP;
      B_CMP: begin
        if (match || idx_q == IW'(RING_DEPTH - 1)) state_d = B_EMIT;
        else state_d = B_READ;
      end
      B_EMIT: begin
        if (!out_vld_q || m_ready_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_d = job_q; idx_d = idx_q; ws_d = ws_q; cnt_d = cnt_q; valid_d = valid_q;
    res_st_d = res_st_q; res_slot_d = res_slot_q;
    out_vld_d = out_vld_q && !m_ready_i;
    out_d = out_q;
    pop_o = 1'b0; ram_we = 1'b0; ram_re = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          idx_d = '0;
          res_st_d = job_i.status;
          res_slot_d = '0;
          if (job_i.kind == JOB_CLEAR) begin
            valid_d = '0;
            ws_d = '0;
            cnt_d = '0;
          end
        end
      end
      B_READ: ram_re = 1'b1;
      B_CMP: begin
        if (match) begin
          res_st_d = ST_DUP;
          res_slot_d = idx_q;
        end else if (idx_q == IW'(RING_DEPTH - 1)) begin
          ram_we = 1'b1;
          valid_d[ws_q] = 1'b1;
          if (!valid_q[ws_q]) cnt_d = cnt_q + CW'(1);
          res_st_d = ST_STORED;
          res_slot_d = ws_q;
          ws_d = (ws_q == IW'(RING_DEPTH - 1)) ? '0 : ws_q + IW'(1);
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      B_EMIT: begin
        if (!out_vld_q || m_ready_i) begin
          out_vld_d = 1'b1;
          out_d = {3'b000, COUNT_W'(cnt_q), SLOT_W'(res_slot_q), res_st_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_slot_q <= res_slot_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q <= '0;
      ws_q <= '0;
      cnt_q <= '0;
      valid_q <= '0;
      res_st_q <= ST_NOT_PROBE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      ws_q <= ws_d;
      cnt_q <= cnt_d;
      valid_q <= valid_d;
      res_st_q <= res_st_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;

endmodule

FILE: src/probe_request_dedup_log_core.sv
// top level of the probe request dedup log
// depends on prdl_pkg, prdl_front, prdl_fifo, prdl_back, prdl_ram
//
// usage:
//   slave stream carries frame bytes, one per beat; tlast marks the last
//   byte of a frame, tuser=1 asks to clear the whole table (data ignored)
//   master stream carries one result beat per frame end or clear request
// flow:
//   the parser takes one byte per cycle; a frame end or clear pushes a job
//   into a two-entry queue, the lookup engine pops it
//   with the engine idle, a clear or non-probe result is registered in the
//   queue entry, then the engine state, then the output register
//   a lookup reads the ring ram one entry at a time, a READ then a CMP state
//   per entry; a hit at slot i ends the scan there, a miss scans all
//   RING_DEPTH slots; that ram port sets the job rate
//   byte beats keep flowing at one per cycle while the queue has room
// reset:
//   ring empty, write slot 0, parser at start of frame; no ram clearing pass
// stall:
//   a stalled result stays in the output register; the engine then holds,
//   the queue fills and tready drops only when both entries are taken
module probe_request_dedup_log_core import prdl_pkg::*; #(
  parameter int RING_DEPTH      = RingDepthDef,
  parameter int MAX_SSID_BYTES  = MaxSsidBytesDef,
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // frame_byte[7:0], is_mgmt[8], rssi[16:9], zero
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[2:0], slot[7:3], used_count[12:8], zero
);

  logic q_full, q_empty, push, pop, accept;
  job_t job_in, job_head;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && s_axis_tready;

  // parser front
  prdl_front #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_clear_i(s_axis_tuser),
    .byte_i     (s_axis_tdata[7:0]),
    .last_i     (s_axis_tlast),
    .mgmt_i     (s_axis_tdata[8]),
    .rssi_i     (s_axis_tdata[16:9]),
    .push_o     (push),
    .job_o      (job_in)
  );

  // decoupling queue
  prdl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // ring lookup and result
  prdl_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .job_i    (job_head),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata)
  );

endmodule

FILE: src/prdl_checker.sv
// port-level checks for the probe request dedup log
// depends on prdl_pkg; bound to probe_request_dedup_log_core
module prdl_checker import prdl_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_CLEARED))
    else $error("bad status code");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == 3'(ST_CLEARED) |-> m_axis_tdata[12:3] == '0)
    else $error("clear result not empty");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(m_axis_tdata[12:8]) <= RING_DEPTH)
    else $error("used count beyond ring");

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == 3'(ST_STORED) |->
      m_axis_tdata[12:8] != '0 && int'(m_axis_tdata[7:3]) < RING_DEPTH)
    else $error("stored result slot or count wrong");

endmodule

bind probe_request_dedup_log_core prdl_checker #(.RING_DEPTH(RING_DEPTH)) u_prdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
